@@ src/tlsm_pkg.sv @@
// Shared types and constants of the transmit latency statistics monitor.
package tlsm_pkg;

  // Input action codes
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Result kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Latency arithmetic constants
  localparam logic signed [33:0] US_PER_SEC   = 34'sd1000000;
  localparam logic signed [32:0] DS_CLAMP_HI  = 33'sd4095;
  localparam logic signed [32:0] DS_CLAMP_LO  = -33'sd4096;
  localparam logic signed [12:0] DSC_HI       = 13'sd4095;
  localparam logic signed [12:0] DSC_LO       = -13'sd4096;
  // ceil(2^34 / 125): exact floor(x / 125) for x below 2^27
  localparam logic [27:0]        RECIP_125    = 28'd137438954;
  localparam int                 RECIP_SHIFT  = 34;
  localparam logic [29:0]        NS_PER_US    = 30'd1000;
  localparam logic signed [34:0] SAT_HI       = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO       = -35'sd2147483648;
  localparam logic signed [31:0] LAT_MAX      = 32'sh7FFFFFFF;
  localparam logic signed [31:0] LAT_MIN      = 32'sh80000000;
  localparam logic [31:0]        CNT_MAX      = 32'hFFFFFFFF;

  // Work kinds handed from the front part to the back part
  typedef enum logic [1:0] {
    OP_MEASURE,
    OP_MISSING,
    OP_REPORT
  } op_t;

  // Back part sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_LAT,
    ST_UPD,
    ST_REPORT
  } state_t;

  // One classified item waiting for the back part
  typedef struct packed {
    op_t                op;
    logic               rec;   // update min, max and histogram
    logic [31:0]        done;  // packets done snapshot for a report
    logic signed [32:0] ds;    // end_sec - start_sec
    logic signed [30:0] dn;    // end_nsec - start_nsec
  } cmd_t;

endpackage

@@ src/tx_latency_stats_monitor_unit.sv @@
// Top level of the transmit latency statistics monitor.
//
// Input channel (in_valid/in_ready): one item per packet (start and end
// timestamps, all-present flag) or a report request. The front part takes
// an item in every cycle while its two-entry command queue has room.
// Output channel (out_valid/out_ready): one packet result per counted packet
// or missing-timestamp packet, and NUM_BINS report entries per report, the
// final one with out_last set. The warm-up packet after reset gives nothing.
// A measured packet passes through the back part in order (queue pop with
// both multiplies, quotient and remainder check, sum, saturate, statistics
// update) before its result sits in the output register; the back part
// works on one command at a time, taking no new command before that. A
// missing-timestamp packet goes straight to the output register; a report
// yields one entry per cycle from the counter port while out_ready is high.
// A stalled receiver holds the output register; the back part waits and the
// queue absorbs up to two more items before in_ready drops.
// Reset clears the packet count, histogram and threshold, sets min/max to
// LAT_MAX/LAT_MIN; no clearing pass is needed. cfg_wr_en sets the threshold.
module tx_latency_stats_monitor_unit import tlsm_pkg::*; #(
  parameter int NUM_BINS        = 12,
  parameter int FIRST_BIN_LIMIT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [31:0]        in_start_sec,
  input  logic [29:0]        in_start_nsec,
  input  logic [31:0]        in_end_sec,
  input  logic [29:0]        in_end_nsec,
  input  logic               in_all_present,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [31:0] out_latency_us,
  output logic               out_over_threshold,
  output logic               out_missing,
  output logic [3:0]         out_bin_index,
  output logic [31:0]        out_bin_count,
  output logic signed [31:0] out_min_latency,
  output logic signed [31:0] out_max_latency,
  output logic [31:0]        out_packets_done,
  output logic               out_last
);

  logic [31:0] threshold_r;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  logic        q_full;
  cmd_t        q_in;
  cmd_t        q_head;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  tlsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_start_sec   (in_start_sec),
    .in_start_nsec  (in_start_nsec),
    .in_end_sec     (in_end_sec),
    .in_end_nsec    (in_end_nsec),
    .in_all_present (in_all_present),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_in)
  );

  tlsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  tlsm_back #(
    .NUM_BINS        (NUM_BINS),
    .FIRST_BIN_LIMIT (FIRST_BIN_LIMIT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .threshold          (threshold_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_latency_us     (out_latency_us),
    .out_over_threshold (out_over_threshold),
    .out_missing        (out_missing),
    .out_bin_index      (out_bin_index),
    .out_bin_count      (out_bin_count),
    .out_min_latency    (out_min_latency),
    .out_max_latency    (out_max_latency),
    .out_packets_done   (out_packets_done),
    .out_last           (out_last)
  );

  // A packet result is always the only result of its item
  a_packet_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PACKET) |-> out_last)
    else $error("packet result without last");

  // Missing timestamps always flag and carry no latency
  a_missing_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_missing) |-> (out_over_threshold && out_latency_us == '0))
    else $error("missing result malformed");

  // Input stalls only while the command queue holds work
  a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // Never pop an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

@@ src/tlsm_front.sv @@
// Front part: accepts items, tracks the packet count and classifies each item.
module tlsm_front import tlsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_start_sec,
  input  logic [29:0] in_start_nsec,
  input  logic [31:0] in_end_sec,
  input  logic [29:0] in_end_nsec,
  input  logic        in_all_present,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [31:0] count_r;
  logic [31:0] count_nxt;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the item and advance the packet count
  always_comb begin
    count_nxt    = count_r;
    q_push       = 1'b0;
    q_cmd.op     = OP_MEASURE;
    q_cmd.rec    = 1'b0;
    q_cmd.done   = '0;
    q_cmd.ds     = $signed({1'b0, in_end_sec} - {1'b0, in_start_sec});
    q_cmd.dn     = $signed({1'b0, in_end_nsec} - {1'b0, in_start_nsec});
    if (accept) begin
      if (in_action == ACT_REPORT) begin
        q_push     = 1'b1;
        q_cmd.op   = OP_REPORT;
        q_cmd.done = (count_r == '0) ? '0 : count_r - 32'd1;
      end else if (count_r == '0) begin
        // warm-up packet: count it, drop it
        count_nxt = 32'd1;
      end else if (!in_all_present) begin
        q_push   = 1'b1;
        q_cmd.op = OP_MISSING;
      end else begin
        q_push    = 1'b1;
        q_cmd.op  = OP_MEASURE;
        q_cmd.rec = (count_r > 32'd1);
        count_nxt = (count_r == CNT_MAX) ? count_r : count_r + 32'd1;
      end
    end
  end

  // Hold the packet count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/tlsm_queue.sv @@
// Short command queue between the front and back parts.
module tlsm_queue import tlsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   level_r;

  assign valid = (level_r != '0);
  assign full  = (level_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        level_r <= level_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

@@ src/tlsm_back.sv @@
// Back part: latency arithmetic, statistics update, report walk and output register.
module tlsm_back import tlsm_pkg::*; #(
  parameter int NUM_BINS        = 12,
  parameter int FIRST_BIN_LIMIT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_head,
  output logic               q_pop,
  input  logic [31:0]        threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [31:0] out_latency_us,
  output logic               out_over_threshold,
  output logic               out_missing,
  output logic [3:0]         out_bin_index,
  output logic [31:0]        out_bin_count,
  output logic signed [31:0] out_min_latency,
  output logic signed [31:0] out_max_latency,
  output logic [31:0]        out_packets_done,
  output logic               out_last
);

  localparam int BIN_W = $clog2(NUM_BINS);

  // Sequencer and work registers
  state_t             state_r, state_nxt;
  logic               rec_r, rec_nxt;
  logic [31:0]        done_r, done_nxt;
  logic signed [33:0] a_r, a_nxt;
  logic [54:0]        p_r, p_nxt;
  logic [29:0]        u_r, u_nxt;
  logic               neg_r, neg_nxt;
  logic [20:0]        qu_r, qu_nxt;
  logic               rnz_r, rnz_nxt;
  logic signed [34:0] s_r, s_nxt;
  logic signed [31:0] lat_r, lat_nxt;
  logic [BIN_W-1:0]   rep_idx_r, rep_idx_nxt;

  // Statistics
  logic signed [31:0] min_r, min_nxt;
  logic signed [31:0] max_r, max_nxt;
  logic [31:0]        bins_r [NUM_BINS];
  logic               bin_we;
  logic [BIN_W-1:0]   bin_sel;
  logic [BIN_W-1:0]   bin_addr;
  logic [31:0]        bin_rd;
  logic [31:0]        bin_inc;

  // Output register
  logic               ov_r, ov_nxt;
  logic               o_kind_r, o_kind_nxt;
  logic signed [31:0] o_lat_r, o_lat_nxt;
  logic               o_over_r, o_over_nxt;
  logic               o_miss_r, o_miss_nxt;
  logic [3:0]         o_bin_r, o_bin_nxt;
  logic [31:0]        o_cnt_r, o_cnt_nxt;
  logic signed [31:0] o_min_r, o_min_nxt;
  logic signed [31:0] o_max_r, o_max_nxt;
  logic [31:0]        o_done_r, o_done_nxt;
  logic               o_last_r, o_last_nxt;

  // Datapath terms
  logic               out_free;
  logic signed [12:0] dsc;
  logic [29:0]        u_head;
  logic [29:0]        qk;
  logic [21:0]        qmag;
  logic signed [22:0] qf;
  logic signed [34:0] sc;
  logic signed [34:0] lat_ext;
  logic [NUM_BINS-2:0] below;
  logic               over;

  assign out_free = !ov_r || out_ready;

  // Clamp the seconds difference; anything outside saturates the same way
  always_comb begin
    if (q_head.ds > DS_CLAMP_HI) begin
      dsc = DSC_HI;
    end else if (q_head.ds < DS_CLAMP_LO) begin
      dsc = DSC_LO;
    end else begin
      dsc = $signed(q_head.ds[12:0]);
    end
    u_head = q_head.dn[30] ? 30'(-q_head.dn) : q_head.dn[29:0];
  end

  // Remainder check, signed quotient and rounding toward zero
  assign qk      = 30'({9'd0, p_r[54:RECIP_SHIFT]} * NS_PER_US);
  assign qmag    = {1'b0, qu_r} + 22'(rnz_r);
  assign qf      = neg_r ? -$signed({1'b0, qmag}) : $signed({2'b00, qu_r});
  assign sc      = s_r + 35'(s_r[34] && rnz_r);
  assign lat_ext = 35'(lat_r);
  assign over    = (threshold != '0) && !lat_r[31] && (lat_r[31:0] > threshold);

  // Histogram bin of the current latency
  always_comb begin
    for (int i = 0; i < NUM_BINS - 1; i++) begin
      below[i] = lat_ext < (35'(FIRST_BIN_LIMIT) << i);
    end
    bin_sel = BIN_W'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (below[i]) begin
        bin_sel = BIN_W'(i);
      end
    end
  end

  assign bin_addr = (state_r == ST_REPORT) ? rep_idx_r : bin_sel;
  assign bin_rd   = bins_r[bin_addr];
  assign bin_inc  = (bin_rd == CNT_MAX) ? bin_rd : bin_rd + 32'd1;

  // Next state and datapath
  always_comb begin
    state_nxt   = state_r;
    rec_nxt     = rec_r;
    done_nxt    = done_r;
    a_nxt       = a_r;
    p_nxt       = p_r;
    u_nxt       = u_r;
    neg_nxt     = neg_r;
    qu_nxt      = qu_r;
    rnz_nxt     = rnz_r;
    s_nxt       = s_r;
    lat_nxt     = lat_r;
    rep_idx_nxt = rep_idx_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    bin_we      = 1'b0;
    q_pop       = 1'b0;
    ov_nxt      = ov_r && !out_ready;
    o_kind_nxt  = o_kind_r;
    o_lat_nxt   = o_lat_r;
    o_over_nxt  = o_over_r;
    o_miss_nxt  = o_miss_r;
    o_bin_nxt   = o_bin_r;
    o_cnt_nxt   = o_cnt_r;
    o_min_nxt   = o_min_r;
    o_max_nxt   = o_max_r;
    o_done_nxt  = o_done_r;
    o_last_nxt  = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_MEASURE: begin
              // multiply seconds to us and start the divide by 1000
              q_pop     = 1'b1;
              rec_nxt   = q_head.rec;
              a_nxt     = 34'(dsc) * US_PER_SEC;
              p_nxt     = 55'(u_head[29:3]) * 55'(RECIP_125);
              u_nxt     = u_head;
              neg_nxt   = q_head.dn[30];
              state_nxt = ST_DIV;
            end
            OP_MISSING: begin
              if (out_free) begin
                q_pop      = 1'b1;
                ov_nxt     = 1'b1;
                o_kind_nxt = KIND_PACKET;
                o_lat_nxt  = '0;
                o_over_nxt = 1'b1;
                o_miss_nxt = 1'b1;
                o_bin_nxt  = '0;
                o_cnt_nxt  = '0;
                o_min_nxt  = '0;
                o_max_nxt  = '0;
                o_done_nxt = '0;
                o_last_nxt = 1'b1;
              end
            end
            OP_REPORT: begin
              q_pop       = 1'b1;
              done_nxt    = q_head.done;
              rep_idx_nxt = '0;
              state_nxt   = ST_REPORT;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        // take the quotient and flag a nonzero remainder
        qu_nxt    = p_r[54:RECIP_SHIFT];
        rnz_nxt   = (u_r != qk);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_LAT;
      end
      ST_LAT: begin
        // s_r holds seconds*1e6 plus the floored nanosecond quotient
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = KIND_PACKET;
          o_lat_nxt  = lat_r;
          o_over_nxt = over;
          o_miss_nxt = 1'b0;
          o_bin_nxt  = '0;
          o_cnt_nxt  = '0;
          o_min_nxt  = '0;
          o_max_nxt  = '0;
          o_done_nxt = '0;
          o_last_nxt = 1'b1;
          if (rec_r) begin
            bin_we = 1'b1;
            if (lat_r < min_r) begin
              min_nxt = lat_r;
            end
            if (lat_r > max_r) begin
              max_nxt = lat_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = KIND_REPORT;
          o_lat_nxt  = '0;
          o_over_nxt = 1'b0;
          o_miss_nxt = 1'b0;
          o_bin_nxt  = 4'(rep_idx_r);
          o_cnt_nxt  = bin_rd;
          o_min_nxt  = min_r;
          o_max_nxt  = max_r;
          o_done_nxt = done_r;
          o_last_nxt = (rep_idx_r == BIN_W'(NUM_BINS - 1));
          if (rep_idx_r == BIN_W'(NUM_BINS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            rep_idx_nxt = rep_idx_r + BIN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Sum and saturate run on their own stage registers
    if (state_r == ST_SUM) begin
      s_nxt = 35'(a_r) + 35'(qf);
    end
    if (state_r == ST_LAT) begin
      if (sc > SAT_HI) begin
        lat_nxt = LAT_MAX;
      end else if (sc < SAT_LO) begin
        lat_nxt = LAT_MIN;
      end else begin
        lat_nxt = sc[31:0];
      end
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold statistics and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= LAT_MAX;
      max_r <= LAT_MIN;
      ov_r  <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      ov_r  <= ov_nxt;
      if (bin_we) begin
        bins_r[bin_sel] <= bin_inc;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    done_r     <= done_nxt;
    a_r        <= a_nxt;
    p_r        <= p_nxt;
    u_r        <= u_nxt;
    neg_r      <= neg_nxt;
    qu_r       <= qu_nxt;
    rnz_r      <= rnz_nxt;
    s_r        <= s_nxt;
    lat_r      <= lat_nxt;
    rep_idx_r  <= rep_idx_nxt;
    o_kind_r   <= o_kind_nxt;
    o_lat_r    <= o_lat_nxt;
    o_over_r   <= o_over_nxt;
    o_miss_r   <= o_miss_nxt;
    o_bin_r    <= o_bin_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
    o_done_r   <= o_done_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kind           = o_kind_r;
  assign out_latency_us     = o_lat_r;
  assign out_over_threshold = o_over_r;
  assign out_missing        = o_miss_r;
  assign out_bin_index      = o_bin_r;
  assign out_bin_count      = o_cnt_r;
  assign out_min_latency    = o_min_r;
  assign out_max_latency    = o_max_r;
  assign out_packets_done   = o_done_r;
  assign out_last           = o_last_r;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the transmit latency statistics monitor unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tlsm_pkg::*;

  localparam int     NUM_BINS        = 12;
  localparam int     FIRST_BIN_LIMIT = 32;
  localparam int     CLK_PERIOD      = 8;
  localparam int     RESET_CYCLES    = 5;
  localparam int     HOLD_CYCLES     = 80;
  localparam int     SETTLE_CYCLES   = 20;
  localparam int     STALL_LIMIT     = 2000;
  localparam int     MAX_SHOWN       = 10;
  localparam longint NS_PER_SEC      = 1000000000;
  localparam longint NS_PER_USEC     = 1000;

  // One packet or report request as offered on the input channel
  typedef struct packed {
    logic        action;
    logic [31:0] start_sec;
    logic [29:0] start_nsec;
    logic [31:0] end_sec;
    logic [29:0] end_nsec;
    logic        all_present;
  } stamp_item_t;

  // One result as seen on the output channel
  typedef struct packed {
    logic               kind;
    logic signed [31:0] latency_us;
    logic               over_threshold;
    logic               missing;
    logic [3:0]         bin_index;
    logic [31:0]        bin_count;
    logic signed [31:0] min_latency;
    logic signed [31:0] max_latency;
    logic [31:0]        packets_done;
    logic               last;
  } stat_result_t;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               cfg_wr_en          = 1'b0;
  logic [31:0]        cfg_wr_data        = '0;
  logic               in_valid           = 1'b0;
  logic               in_ready;
  logic               in_action          = ACT_PACKET;
  logic [31:0]        in_start_sec       = '0;
  logic [29:0]        in_start_nsec      = '0;
  logic [31:0]        in_end_sec         = '0;
  logic [29:0]        in_end_nsec        = '0;
  logic               in_all_present     = 1'b0;
  logic               out_valid;
  logic               out_ready          = 1'b0;
  logic               out_kind;
  logic signed [31:0] out_latency_us;
  logic               out_over_threshold;
  logic               out_missing;
  logic [3:0]         out_bin_index;
  logic [31:0]        out_bin_count;
  logic signed [31:0] out_min_latency;
  logic signed [31:0] out_max_latency;
  logic [31:0]        out_packets_done;
  logic               out_last;

  tx_latency_stats_monitor_unit #(
    .NUM_BINS       (NUM_BINS),
    .FIRST_BIN_LIMIT(FIRST_BIN_LIMIT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_start_sec      (in_start_sec),
    .in_start_nsec     (in_start_nsec),
    .in_end_sec        (in_end_sec),
    .in_end_nsec       (in_end_nsec),
    .in_all_present    (in_all_present),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_latency_us    (out_latency_us),
    .out_over_threshold(out_over_threshold),
    .out_missing       (out_missing),
    .out_bin_index     (out_bin_index),
    .out_bin_count     (out_bin_count),
    .out_min_latency   (out_min_latency),
    .out_max_latency   (out_max_latency),
    .out_packets_done  (out_packets_done),
    .out_last          (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Items waiting to be offered, and results the block still owes
  stamp_item_t  pending_items[$];
  stat_result_t expected_results[$];

  // Shadow of the block's register and statistics
  logic [31:0]        thr_us = '0;
  logic [31:0]        pkt_count = '0;
  logic signed [31:0] lat_floor = LAT_MAX;
  logic signed [31:0] lat_peak = LAT_MIN;
  logic [31:0]        bin_tally[NUM_BINS] = '{default: '0};

  // Pacing knobs set by the sequence, used by the driver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // Bookkeeping
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int n_pushed = 0;
  int n_taken = 0;
  int n_reports = 0;
  int n_results = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  // Work out the results of one accepted item and advance the shadow state
  task automatic account_item(input stamp_item_t it);
    stat_result_t r;
    longint span_ns, lat_l, thr_l;
    int b, i;
    if (it.action == ACT_REPORT) begin
      for (b = 0; b < NUM_BINS; b++) begin
        r = '0;
        r.kind = KIND_REPORT;
        r.bin_index = b[3:0];
        r.bin_count = bin_tally[b];
        r.min_latency = lat_floor;
        r.max_latency = lat_peak;
        r.packets_done = (pkt_count != 0) ? pkt_count - 32'd1 : 32'd0;
        r.last = (b == NUM_BINS - 1);
        expected_results.push_back(r);
      end
    end else if (pkt_count == 0) begin
      // warm-up packet: silent
      pkt_count = 32'd1;
    end else begin
      r = '0;
      r.kind = KIND_PACKET;
      r.last = 1'b1;
      if (!it.all_present) begin
        r.over_threshold = 1'b1;
        r.missing = 1'b1;
      end else begin
        span_ns = (longint'(it.end_sec) - longint'(it.start_sec)) * NS_PER_SEC
                  + (longint'(it.end_nsec) - longint'(it.start_nsec));
        lat_l = span_ns / NS_PER_USEC;
        if (lat_l > LAT_MAX) lat_l = LAT_MAX;
        if (lat_l < LAT_MIN) lat_l = LAT_MIN;
        thr_l = longint'(thr_us);
        r.latency_us = lat_l[31:0];
        r.over_threshold = (thr_us != 0) && (lat_l > thr_l);
        // the second packet is reported only
        if (pkt_count > 1) begin
          if (r.latency_us < lat_floor) lat_floor = r.latency_us;
          if (r.latency_us > lat_peak) lat_peak = r.latency_us;
          b = NUM_BINS - 1;
          for (i = NUM_BINS - 2; i >= 0; i--) begin
            if (lat_l < (longint'(FIRST_BIN_LIMIT) << i)) b = i;
          end
          if (bin_tally[b] != CNT_MAX) bin_tally[b]++;
        end
        if (pkt_count != CNT_MAX) pkt_count++;
      end
      expected_results.push_back(r);
    end
  endtask

  function automatic string fmt_result(stat_result_t r);
    return {$sformatf("kind=%0d lat=%0d over=%0d miss=%0d bin=%0d cnt=%0d ",
                      r.kind, r.latency_us, r.over_threshold, r.missing, r.bin_index,
                      r.bin_count),
            $sformatf("min=%0d max=%0d done=%0d last=%0d",
                      r.min_latency, r.max_latency, r.packets_done, r.last)};
  endfunction

  function automatic stamp_item_t stamp(logic action, logic [31:0] ssec, logic [29:0] snsec,
                                        logic [31:0] esec, logic [29:0] ensec, logic present);
    return {action, ssec, snsec, esec, ensec, present};
  endfunction

  // Packet whose end lies delta_ns after its start, with nanoseconds normalized
  function automatic stamp_item_t after_delay(logic [31:0] ssec, logic [29:0] snsec,
                                              longint delta_ns, logic present);
    longint t, s, borrow;
    t = longint'(snsec) + delta_ns;
    s = longint'(ssec);
    if (t < 0) begin
      borrow = (-t + NS_PER_SEC - 1) / NS_PER_SEC;
      t += borrow * NS_PER_SEC;
      s -= borrow;
    end
    s += t / NS_PER_SEC;
    t = t % NS_PER_SEC;
    return stamp(ACT_PACKET, ssec, snsec, s[31:0], t[29:0], present);
  endfunction

  // Packet with a latency of exactly lat_us after truncation
  function automatic stamp_item_t packet_us(int lat_us);
    longint delta;
    delta = longint'(lat_us) * NS_PER_USEC + ((lat_us >= 0) ? 999 : -999);
    return after_delay($urandom_range(1000, 32'hFFFF0000), 30'($urandom_range(0, 999999999)),
                       delta, 1'b1);
  endfunction

  function automatic stamp_item_t report_req();
    return stamp(ACT_REPORT, $urandom, 30'($urandom), $urandom, 30'($urandom),
                 1'($urandom_range(0, 1)));
  endfunction

  // Packet with arbitrary timestamps and all_present cleared
  function automatic stamp_item_t missing_pkt();
    return stamp(ACT_PACKET, $urandom, 30'($urandom), $urandom, 30'($urandom), 1'b0);
  endfunction

  // Mostly plausible packets over all bins, some reports, gaps and noise
  function automatic stamp_item_t random_item();
    int pick;
    longint delta;
    pick = $urandom_range(99);
    if (pick < 8) return report_req();
    if (pick < 18)
      return stamp(ACT_PACKET, $urandom, 30'($urandom_range(0, 30'h3FFFFFFF)), $urandom,
                   30'($urandom_range(0, 30'h3FFFFFFF)), 1'($urandom_range(0, 1)));
    delta = longint'($urandom_range(0, 40 << $urandom_range(0, 11))) * NS_PER_USEC
            + $urandom_range(0, 999);
    if (pick < 22) delta = -delta;
    else if (pick < 26) delta += longint'($urandom_range(1, 3)) * NS_PER_SEC;
    return after_delay($urandom, 30'($urandom_range(0, 999999999)), delta,
                       !(pick >= 26 && pick < 34));
  endfunction

  task automatic offer(input stamp_item_t it);
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic offer_random(input int count);
    int k;
    for (k = 0; k < count; k++) offer(random_item());
  endtask

  // Wait until every offered item is taken and answered, then let the block settle
  task automatic drain();
    while (n_taken != n_pushed || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    thr_us = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sample both channels, check results, watch for a hang
  always @(posedge clk) begin
    stamp_item_t  taken;
    stat_result_t seen, want;
    if (rst_n) begin
      in_fire = in_valid && in_ready;
      out_fire = out_valid && out_ready;
      if (in_fire) begin
        taken = {in_action, in_start_sec, in_start_nsec, in_end_sec, in_end_nsec,
                 in_all_present};
        if (taken.action == ACT_REPORT) n_reports++;
        account_item(taken);
        n_taken++;
      end
      if (out_fire) begin
        seen = {out_kind, out_latency_us, out_over_threshold, out_missing, out_bin_index,
                out_bin_count, out_min_latency, out_max_latency, out_packets_done, out_last};
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d arrived with nothing expected: %s", n_results, fmt_result(seen));
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("result %0d mismatch", n_results);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(seen));
            end
          end
        end
      end
      // abort when nothing moves for too long
      if (in_fire || out_fire) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Drive the input channel from the pending queue
  always @(negedge clk) begin
    stamp_item_t next_item;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          {in_action, in_start_sec, in_start_nsec, in_end_sec, in_end_nsec,
           in_all_present} <= next_item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pace the receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 69;

    // Directed: empty statistics, warm-up, unrecorded second packet
    offer(report_req());
    offer(missing_pkt());
    offer(report_req());
    offer(packet_us(5));
    offer(report_req());
    offer(missing_pkt());
    // bin edges, truncation of a negative span, zero latency
    offer(packet_us(31));
    offer(packet_us(32));
    offer(packet_us(63));
    offer(packet_us(64));
    offer(packet_us(32767));
    offer(packet_us(32768));
    offer(packet_us(-1));
    offer(packet_us(0));
    // saturation both ways and nanoseconds above one second
    offer(stamp(ACT_PACKET, 32'd0, 30'd0, 32'hFFFFFFFF, 30'd999999999, 1'b1));
    offer(stamp(ACT_PACKET, 32'hFFFFFFFF, 30'h3FFFFFFF, 32'd0, 30'd0, 1'b1));
    offer(stamp(ACT_PACKET, 32'd10, 30'h3FFFFFFF, 32'd12, 30'd0, 1'b1));
    offer(report_req());
    drain();

    // Directed: threshold edges
    write_threshold(32'd100);
    offer(packet_us(100));
    offer(packet_us(101));
    offer(packet_us(-50));
    offer(missing_pkt());
    offer(report_req());
    offer_random(110);
    drain();

    // Slow sender, mostly ready receiver
    send_idle_pct = 69;
    recv_idle_pct = 22;
    write_threshold(32'hFFFFFFFF);
    offer_random(50);
    drain();
    write_threshold(32'd1);
    offer_random(50);
    drain();

    // Full rate, with a long receiver hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(32'd2000);
    offer(report_req());
    offer_random(60);
    hold_req = 1'b1;
    drain();
    write_threshold(32'd0);
    offer_random(30);
    drain();

    mismatches += expected_results.size();
    $display("covered %0d items (%0d reports) and %0d results, thresholds 0, 1, 100, 2000, max",
             n_taken, n_reports, n_results);
    $display("paced slow/fast on both sides, with one long output hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
